// ===== design/efms_pkg.sv =====
// Package for the earliest-free machine scheduler: sizes, payload structs,
// the cell control struct and the controller state type. No dependencies.
`timescale 1ns / 1ps

package efms_pkg;

    localparam int MAX_MACHINES = 64;
    localparam int TIME_BITS    = 32;
    localparam int FIELD_BITS   = 31;
    localparam int COUNT_BITS   = $clog2(MAX_MACHINES + 1);
    localparam int CFG_BITS     = 7;
    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(64);

    typedef logic [TIME_BITS-1:0]  time_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] start_time;
        logic [FIELD_BITS-1:0] duration;
    } job_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] finish_time;
        logic [TIME_BITS-1:0] makespan;
    } result_t;

    // Broadcast to every cell of the sorted chain.
    typedef struct packed {
        logic  load;
        logic  replace;
        time_t key;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_UPDATE
    } state_t;

endpackage

// ===== design/earliest_free_machine_scheduler.sv =====
// Earliest-free machine scheduler top level: controller, configuration
// register and the chain of efms_cell instances. Uses efms_pkg and efms_cell.
`timescale 1ns / 1ps

// A job is taken when start is high and busy is low. In ST_CALC the finish
// time is formed from the job's start and duration and, once every machine
// is busy, the earliest finish time; in ST_UPDATE the chain of cells takes
// it in sorted order. Busy stays high in both states. In ST_UPDATE done is
// high for exactly one cycle with finish_time and makespan on result; the
// receiver must take it then, since it cannot hold results off. A new job can
// be taken in the cycle that follows done. Finish times saturate at all ones.
// The machine count is written through cfg_valid/cfg_ready/cfg_data; the
// user must write it only while the block is idle, which the block does not
// enforce. Zero counts as one and values above 64 as 64.
module earliest_free_machine_scheduler (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  efms_pkg::job_t                      job,
    output logic                                done,
    output efms_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [efms_pkg::CFG_BITS-1:0]       cfg_data
);

    efms_pkg::state_t   state_reg;
    efms_pkg::state_t   state_next;

    logic [efms_pkg::CFG_BITS-1:0] count_cfg_reg;
    efms_pkg::count_t   in_use;
    efms_pkg::count_t   fill_reg;
    efms_pkg::time_t    makespan_reg;
    efms_pkg::time_t    fin_reg;
    logic               replace_reg;
    efms_pkg::job_t     job_reg;

    efms_pkg::cell_ctl_t cell_ctl;
    efms_pkg::time_t    cell_val [efms_pkg::MAX_MACHINES];
    logic               cell_le  [efms_pkg::MAX_MACHINES];

    logic               accept;
    logic               full;
    efms_pkg::time_t    begin_time;
    logic [efms_pkg::TIME_BITS:0] sum;
    efms_pkg::time_t    fin_sat;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // Clamp the configured machine count into 1..MAX_MACHINES.
    always_comb
    begin
        if (count_cfg_reg == '0)
            in_use = efms_pkg::COUNT_BITS'(1);
        else if (efms_pkg::COUNT_BITS'(count_cfg_reg) > efms_pkg::COUNT_BITS'(efms_pkg::MAX_MACHINES))
            in_use = efms_pkg::COUNT_BITS'(efms_pkg::MAX_MACHINES);
        else
            in_use = efms_pkg::COUNT_BITS'(count_cfg_reg);
    end

    assign full = (fill_reg >= in_use);

    // Once every machine is busy the job waits for the earliest finish time,
    // which sits in the front cell of the chain.
    always_comb
    begin
        begin_time = efms_pkg::TIME_BITS'(job_reg.start_time);
        if (full && (cell_val[0] > begin_time))
            begin_time = cell_val[0];
        sum = {1'b0, begin_time} + (efms_pkg::TIME_BITS + 1)'(job_reg.duration);
        fin_sat = sum[efms_pkg::TIME_BITS] ? '1 : sum[efms_pkg::TIME_BITS-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            efms_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = efms_pkg::ST_CALC;
            end
            efms_pkg::ST_CALC:
                state_next = efms_pkg::ST_UPDATE;
            efms_pkg::ST_UPDATE:
                state_next = efms_pkg::ST_IDLE;
            default:
                state_next = efms_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy = 1'b1;
        done = 1'b0;
        cell_ctl.load    = 1'b0;
        cell_ctl.replace = replace_reg;
        cell_ctl.key     = fin_reg;
        case (state_reg)
            efms_pkg::ST_IDLE:
                busy = 1'b0;
            efms_pkg::ST_CALC:
                busy = 1'b1;
            efms_pkg::ST_UPDATE:
            begin
                done = 1'b1;
                cell_ctl.load = 1'b1;
            end
            default:
                busy = 1'b0;
        endcase
    end

    assign result.finish_time = fin_reg;
    assign result.makespan    = makespan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= efms_pkg::ST_IDLE;
            count_cfg_reg <= efms_pkg::CFG_RESET;
            fill_reg      <= '0;
            makespan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                count_cfg_reg <= cfg_data;
            if (state_reg == efms_pkg::ST_CALC && fin_sat > makespan_reg)
                makespan_reg <= fin_sat;
            if (state_reg == efms_pkg::ST_UPDATE && !replace_reg)
                fill_reg <= fill_reg + efms_pkg::COUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            job_reg <= job;
        if (state_reg == efms_pkg::ST_CALC)
        begin
            fin_reg     <= fin_sat;
            replace_reg <= full;
        end
    end

    for (genvar i = 0; i < efms_pkg::MAX_MACHINES; i++)
    begin : g_cell
        efms_pkg::time_t lv;
        efms_pkg::time_t rv;
        logic            ll;
        logic            rl;
        logic            act;

        if (i == 0)
        begin : g_front
            assign lv = '0;
            assign ll = 1'b0;
        end
        else
        begin : g_mid
            assign lv = cell_val[i-1];
            assign ll = cell_le[i-1];
        end

        if (i == efms_pkg::MAX_MACHINES - 1)
        begin : g_back
            assign rv = '0;
            assign rl = 1'b0;
        end
        else
        begin : g_inner
            assign rv = cell_val[i+1];
            assign rl = cell_le[i+1];
        end

        assign act = (efms_pkg::COUNT_BITS'(i) < fill_reg);

        efms_cell u_cell (
            .clk       (clk),
            .ctl       (cell_ctl),
            .first     (i == 0),
            .active    (act),
            .left_val  (lv),
            .left_le   (ll),
            .right_val (rv),
            .right_le  (rl),
            .val       (cell_val[i]),
            .le        (cell_le[i])
        );
    end

endmodule

// ===== design/efms_cell.sv =====
// One cell of the sorted finish-time chain: holds one finish time and trades
// values with its neighbors on insert and on replace-minimum. Uses efms_pkg.
`timescale 1ns / 1ps

module efms_cell (
    input  logic               clk,
    input  efms_pkg::cell_ctl_t ctl,
    input  logic               first,
    input  logic               active,
    input  efms_pkg::time_t    left_val,
    input  logic               left_le,
    input  efms_pkg::time_t    right_val,
    input  logic               right_le,
    output efms_pkg::time_t    val,
    output logic               le
);

    efms_pkg::time_t val_reg;
    efms_pkg::time_t val_next;

    // The chain is sorted, so the cells whose value is at or below the key
    // form a prefix; the key lands just after it.
    assign le  = active && (val_reg <= ctl.key);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctl.load)
        begin
            if (ctl.replace)
            begin
                // The minimum leaves from the front: everything up to the key
                // moves one place toward the front.
                if (right_le)
                    val_next = right_val;
                else if (first || le)
                    val_next = ctl.key;
            end
            else
            begin
                // Insert: everything above the key moves one place back.
                if (!le)
                begin
                    if (first || left_le)
                        val_next = ctl.key;
                    else
                        val_next = left_val;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// ===== verif/earliest_free_machine_scheduler_checker.sv =====
// Checker for the earliest-free machine scheduler. It follows the job, result
// and machine-count transactions, predicts each result and compares it field by field.
// Depends on efms_pkg.
`timescale 1ns / 1ps

module earliest_free_machine_scheduler_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  efms_pkg::job_t                job,
    input  logic                          done,
    input  efms_pkg::result_t             result,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [efms_pkg::CFG_BITS-1:0] cfg_data,
    output int                            error_count,
    output int                            pending_count,
    output int                            checked_count
);

    efms_pkg::time_t               free_at [efms_pkg::MAX_MACHINES];
    int                            machines_busy;
    efms_pkg::time_t               makespan_so_far;
    logic [efms_pkg::CFG_BITS-1:0] machine_count;
    efms_pkg::result_t             expected_results [$];
    int                            mismatches;
    int                            results_seen;

    // Only the earliest finish time matters for the result, so a plain array
    // searched for its minimum stands in for the heap.
    function automatic efms_pkg::result_t schedule_job(efms_pkg::job_t j);
        efms_pkg::time_t              ready;
        efms_pkg::time_t              length;
        efms_pkg::time_t              begin_at;
        efms_pkg::time_t              fin;
        logic [efms_pkg::TIME_BITS:0] sum;
        int                           in_use;
        int                           slot;
        efms_pkg::result_t            r;
        ready  = efms_pkg::time_t'(j.start_time);
        length = efms_pkg::time_t'(j.duration);
        if (machine_count == 0)
            in_use = 1;
        else if (machine_count > efms_pkg::MAX_MACHINES)
            in_use = efms_pkg::MAX_MACHINES;
        else
            in_use = int'(machine_count);
        slot = machines_busy;
        if (machines_busy >= in_use)
        begin
            // The busy count never shrinks, so a lowered machine count still
            // searches every busy machine.
            slot = 0;
            for (int m = 1; m < machines_busy; m++)
            begin
                if (free_at[m] < free_at[slot])
                    slot = m;
            end
            begin_at = (free_at[slot] > ready) ? free_at[slot] : ready;
        end
        else
        begin
            begin_at = ready;
            machines_busy++;
        end
        sum = {1'b0, begin_at} + {1'b0, length};
        fin = sum[efms_pkg::TIME_BITS] ? '1 : sum[efms_pkg::TIME_BITS-1:0];
        free_at[slot] = fin;
        if (fin > makespan_so_far)
            makespan_so_far = fin;
        r.finish_time = fin;
        r.makespan    = makespan_so_far;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        efms_pkg::result_t want;
        if (!rst_n)
        begin
            machines_busy   = 0;
            makespan_so_far = '0;
            machine_count   = efms_pkg::CFG_RESET;
            expected_results.delete();
            mismatches      = 0;
            results_seen    = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transaction: finish_time %0h makespan %0h",
                           result.finish_time, result.makespan);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.finish_time !== want.finish_time)
                    begin
                        $error("finish_time: expected %0h, actual %0h",
                               want.finish_time, result.finish_time);
                        mismatches++;
                    end
                    if (result.makespan !== want.makespan)
                    begin
                        $error("makespan: expected %0h, actual %0h",
                               want.makespan, result.makespan);
                        mismatches++;
                    end
                    results_seen++;
                end
            end
            if (start && !busy)
                expected_results.push_back(schedule_job(job));
            if (cfg_valid && cfg_ready)
                machine_count = cfg_data;
        end
        error_count   <= mismatches;
        pending_count <= expected_results.size();
        checked_count <= results_seen;
    end

endmodule

// ===== verif/earliest_free_machine_scheduler_tb.sv =====
// Testbench top for the earliest-free machine scheduler: clock, reset, job and
// machine-count stimulus, and the verdict. Depends on efms_pkg, the block and
// earliest_free_machine_scheduler_checker.
`timescale 1ns / 1ps

module earliest_free_machine_scheduler_tb;

    localparam int                              CYCLE_LIMIT    = 200000;
    localparam int                              JOBS_PER_PHASE = 90;
    localparam logic [efms_pkg::FIELD_BITS-1:0] FIELD_MAX      = '1;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    efms_pkg::job_t                job;
    logic                          done;
    efms_pkg::result_t             result;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [efms_pkg::CFG_BITS-1:0] cfg_data;

    int error_count;
    int pending_count;
    int checked_count;
    int jobs_sent = 0;
    int counts_written = 0;
    int cycle_count = 0;

    earliest_free_machine_scheduler i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .job       (job),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    earliest_free_machine_scheduler_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .job           (job),
        .done          (done),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Holds start high with the job until the block takes the transaction.
    task automatic send_job(input logic [efms_pkg::FIELD_BITS-1:0] s,
                            input logic [efms_pkg::FIELD_BITS-1:0] d);
        @(negedge clk);
        start <= 1'b1;
        job   <= {s, d};
        do
            @(posedge clk);
        while (busy);
        jobs_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // Stops sending and waits until every expected result has come back.
    task automatic drain_jobs();
        @(negedge clk);
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0 || busy);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_machine_count(input logic [efms_pkg::CFG_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        counts_written++;
    endtask

    task automatic send_random_job();
        logic [efms_pkg::FIELD_BITS-1:0] s;
        logic [efms_pkg::FIELD_BITS-1:0] d;
        int                              pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            s = efms_pkg::FIELD_BITS'($urandom);
            d = efms_pkg::FIELD_BITS'($urandom);
        end
        else if (pick == 1)
        begin
            s = ($urandom_range(0, 1) != 0) ? FIELD_MAX : '0;
            d = ($urandom_range(0, 1) != 0) ? FIELD_MAX : '0;
        end
        else
        begin
            s = efms_pkg::FIELD_BITS'($urandom_range(0, 5000));
            d = efms_pkg::FIELD_BITS'($urandom_range(0, 300));
        end
        send_job(s, d);
    endtask

    // Bursts of random length with random gaps, now and then a long burst.
    task automatic random_phase(input int n_jobs);
        int left;
        int burst;
        left = n_jobs;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            if ($urandom_range(0, 7) == 0)
                burst = 40;
            for (int k = 0; k < burst && left > 0; k++)
            begin
                send_random_job();
                left--;
            end
            pause_sender($urandom_range(0, 6));
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        job       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Idle machines at the reset count, field extremes included.
        send_job('0, '0);
        send_job(FIELD_MAX, FIELD_MAX);
        send_job(FIELD_MAX, '0);
        send_job('0, FIELD_MAX);
        send_job(31'd100, 31'd5);
        send_job(31'd3, 31'd2);
        drain_jobs();

        // A count of zero acts as one while six machines stay busy; the job after
        // the six starts on a machine freed near the top of the range and
        // saturates.
        write_machine_count('0);
        repeat (6) send_job(FIELD_MAX, FIELD_MAX);
        send_job('0, FIELD_MAX);
        send_job('0, '0);
        drain_jobs();

        // Above the machine limit the count is clamped, so idle machines
        // take jobs again.
        write_machine_count(efms_pkg::CFG_BITS'(127));
        send_job(31'd1, 31'd1);
        send_job(31'd7, '0);
        drain_jobs();

        write_machine_count(efms_pkg::CFG_BITS'(20));
        random_phase(JOBS_PER_PHASE);
        drain_jobs();
        write_machine_count(efms_pkg::CFG_BITS'(3));
        random_phase(JOBS_PER_PHASE);
        drain_jobs();
        write_machine_count(efms_pkg::CFG_BITS'(45));
        random_phase(JOBS_PER_PHASE);
        drain_jobs();
        write_machine_count(efms_pkg::CFG_BITS'($urandom_range(0, 127)));
        random_phase(JOBS_PER_PHASE);
        drain_jobs();
        write_machine_count(efms_pkg::CFG_BITS'(64));
        random_phase(JOBS_PER_PHASE);
        drain_jobs();
        repeat (10) @(posedge clk);

        $display("Sent %0d jobs and checked %0d results across %0d machine-count writes,",
                 jobs_sent, checked_count, counts_written);
        $display("covering counts of 0, 3, 20, 45, 64, 127 and one random count.");
        if (error_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
